>>> hdl/tpr_pkg.sv
package tpr_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_BYTE  = 2'd3
    } item_kind_t;

    // Register map
    typedef enum logic [1:0] {
        PORT_STATUS   = 2'd0,
        PORT_COMMAND  = 2'd1,
        PORT_DATA     = 2'd2,
        PORT_UNMAPPED = 2'd3
    } port_sel_t;

    // Command codes written to the command register
    localparam logic [31:0] CMD_CLR_RIRQ = 32'd1;
    localparam logic [31:0] CMD_CLR_WIRQ = 32'd2;
    localparam logic [31:0] CMD_EN_WIRQ  = 32'd3;
    localparam logic [31:0] CMD_DIS_WIRQ = 32'd4;

    // Status word bit positions
    localparam int ST_RAVAIL = 0;
    localparam int ST_WBUSY  = 1;
    localparam int ST_RIRQ   = 2;
    localparam int ST_WIRQ   = 3;
    localparam int ST_WIRQE  = 4;
    localparam int ST_BADCMD = 5;

    localparam int INTERVAL_W = 24;
    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CPU_W      = 4;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

endpackage

>>> hdl/terminal_port_registers_unit.sv
// Byte terminal port register block. Each input item is a bus read, a bus write,
// a time tick or a byte arriving from the host (kind in s_tuser); each item gives
// exactly one result item carrying the read data, the receive/transmit events and
// the current interrupt request and target CPU. An item is accepted every clock
// while no remainder pass runs and the result register is free or being drained,
// and its result appears in the next cycle. Writing send_interval starts a
// bit-serial remainder pass (one counter bit a cycle) that realigns the transmit
// slot phase with the free-running slot counter; s_tready stays low while it runs.
// After reset no pass is needed.
module terminal_port_registers_unit #(
    parameter int NUM_CPUS          = 16,
    parameter int SLOT_COUNTER_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wen,
    input  logic [tpr_pkg::INTERVAL_W-1:0]    cfg_wdata,   // send_interval

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        s_tuser,     // command (item kind)
    // [1:0] port, [33:2] write_data, [41:34] rx_byte, [45:42] target_cpu, rest 0
    input  logic [tpr_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_data, [32] rx_taken, [33] tx_valid, [41:34] tx_byte,
    // [42] irq_request, [46:43] irq_cpu, [47] 0
    output logic [tpr_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tpr_pkg::*;

    localparam int CNT_W = (SLOT_COUNTER_BITS > 1) ? $clog2(SLOT_COUNTER_BITS) : 1;

    // Unpacked input fields
    item_kind_t          in_kind;
    port_sel_t           in_port;
    logic [DATA_W-1:0]   in_wdata;
    logic [BYTE_W-1:0]   in_rbyte;
    logic [CPU_W-1:0]    in_target;

    assign in_kind   = item_kind_t'(s_tuser);
    assign in_port   = port_sel_t'(s_tdata[1:0]);
    assign in_wdata  = s_tdata[33:2];
    assign in_rbyte  = s_tdata[41:34];
    assign in_target = s_tdata[45:42];

    // Port state
    logic                          rx_full_reg, rx_full_next;
    logic [BYTE_W-1:0]             rx_hold_reg, rx_hold_next;
    logic                          tx_full_reg, tx_full_next;
    logic [BYTE_W-1:0]             tx_hold_reg, tx_hold_next;
    logic                          rirq_reg, rirq_next;
    logic                          wirq_reg, wirq_next;
    logic                          wirqe_reg, wirqe_next;
    logic                          badcmd_reg, badcmd_next;
    logic [CPU_W-1:0]              cpu_reg, cpu_next;
    logic [SLOT_COUNTER_BITS-1:0]  slot_reg, slot_next;

    // Slot phase = slot counter mod effective interval, kept incrementally
    logic [INTERVAL_W-1:0]         interval_reg;
    logic [INTERVAL_W-1:0]         phase_reg, phase_next;
    logic [INTERVAL_W-1:0]         eff_interval;
    logic                          busy_reg;
    logic [CNT_W-1:0]              bit_cnt_reg;

    // Result register
    logic                          m_valid_reg;
    logic [M_TDATA_W-1:0]          m_data_reg, m_data_next;

    logic                          accept;
    logic [DATA_W-1:0]             rdata;
    logic                          taken, sent;
    logic [BYTE_W-1:0]             sent_byte;
    logic [DATA_W-1:0]             status_word;
    logic [CPU_W-1:0]              target_mod;
    logic                          irq_next;

    // Divider step
    logic [INTERVAL_W:0]           trial;
    logic                          trial_ge;

    assign eff_interval = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
    assign s_tready     = !busy_reg && (!m_valid_reg || m_tready);
    assign accept       = s_tvalid && s_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;

    // target CPU modulo the CPU count, as a small constant table
    always_comb begin
        target_mod = '0;
        for (int k = 0; k < (1 << CPU_W); k++) begin
            if (in_target == CPU_W'(k)) target_mod = CPU_W'(k % NUM_CPUS);
        end
    end

    always_comb begin
        status_word = '0;
        status_word[ST_RAVAIL] = rx_full_reg;
        status_word[ST_WBUSY]  = tx_full_reg;
        status_word[ST_RIRQ]   = rirq_reg;
        status_word[ST_WIRQ]   = wirq_reg;
        status_word[ST_WIRQE]  = wirqe_reg;
        status_word[ST_BADCMD] = badcmd_reg;
    end

    assign trial    = {phase_reg, slot_reg[bit_cnt_reg]};
    assign trial_ge = trial >= {1'b0, eff_interval};

    always_comb begin
        rx_full_next = rx_full_reg;
        rx_hold_next = rx_hold_reg;
        tx_full_next = tx_full_reg;
        tx_hold_next = tx_hold_reg;
        rirq_next    = rirq_reg;
        wirq_next    = wirq_reg;
        wirqe_next   = wirqe_reg;
        badcmd_next  = badcmd_reg;
        cpu_next     = cpu_reg;
        slot_next    = slot_reg;
        phase_next   = phase_reg;
        rdata        = '0;
        taken        = 1'b0;
        sent         = 1'b0;
        sent_byte    = '0;

        case (in_kind)
            KIND_READ: begin
                if (in_port == PORT_STATUS) begin
                    rdata = status_word;
                end else if (in_port == PORT_DATA && rx_full_reg) begin
                    rdata        = DATA_W'(rx_hold_reg);
                    rx_full_next = 1'b0;
                end
            end
            KIND_WRITE: begin
                if (in_port == PORT_COMMAND) begin
                    badcmd_next = 1'b0;
                    case (in_wdata)
                        CMD_CLR_RIRQ: rirq_next   = 1'b0;
                        CMD_CLR_WIRQ: wirq_next   = 1'b0;
                        CMD_EN_WIRQ:  wirqe_next  = 1'b1;
                        CMD_DIS_WIRQ: wirqe_next  = 1'b0;
                        default:      badcmd_next = 1'b1;
                    endcase
                end else if (in_port == PORT_DATA && !tx_full_reg) begin
                    tx_hold_next = in_wdata[BYTE_W-1:0];
                    tx_full_next = 1'b1;
                end
            end
            KIND_TICK: begin
                if (phase_reg == '0 && tx_full_reg) begin
                    sent         = 1'b1;
                    sent_byte    = tx_hold_reg;
                    tx_full_next = 1'b0;
                    wirq_next    = 1'b1;
                    if (!rirq_reg && !wirq_reg) cpu_next = target_mod;
                end
                slot_next = slot_reg + 1'b1;
                // counter wrap restarts the phase; otherwise step it mod interval
                if (slot_reg == '1) begin
                    phase_next = '0;
                end else if (phase_reg + 1'b1 == eff_interval) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            default: begin
                if (!rx_full_reg) begin
                    rx_hold_next = in_rbyte;
                    rx_full_next = 1'b1;
                    taken        = 1'b1;
                    rirq_next    = 1'b1;
                    if (!rirq_reg && !wirq_reg) cpu_next = target_mod;
                end
            end
        endcase

        if (busy_reg) begin
            // restoring remainder step, MSB first
            phase_next = trial_ge ? INTERVAL_W'(trial - {1'b0, eff_interval})
                                  : INTERVAL_W'(trial);
        end

        irq_next    = rirq_next || (wirq_next && wirqe_next);
        m_data_next = {1'b0, cpu_next, irq_next, sent_byte, sent, taken, rdata};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_full_reg  <= 1'b0;
            rx_hold_reg  <= '0;
            tx_full_reg  <= 1'b0;
            tx_hold_reg  <= '0;
            rirq_reg     <= 1'b0;
            wirq_reg     <= 1'b0;
            wirqe_reg    <= 1'b1;
            badcmd_reg   <= 1'b0;
            cpu_reg      <= '0;
            slot_reg     <= '0;
            phase_reg    <= '0;
            interval_reg <= INTERVAL_W'(1);
            busy_reg     <= 1'b0;
            bit_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                rx_full_reg <= rx_full_next;
                rx_hold_reg <= rx_hold_next;
                tx_full_reg <= tx_full_next;
                tx_hold_reg <= tx_hold_next;
                rirq_reg    <= rirq_next;
                wirq_reg    <= wirq_next;
                wirqe_reg   <= wirqe_next;
                badcmd_reg  <= badcmd_next;
                cpu_reg     <= cpu_next;
                slot_reg    <= slot_next;
            end

            // new interval: recompute phase from scratch, one counter bit a cycle
            if (cfg_wen) begin
                interval_reg <= cfg_wdata;
                phase_reg    <= '0;
                busy_reg     <= 1'b1;
                bit_cnt_reg  <= CNT_W'(SLOT_COUNTER_BITS - 1);
            end else if (busy_reg) begin
                phase_reg <= phase_next;
                if (bit_cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
            end else if (accept) begin
                phase_reg <= phase_next;
            end

            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> bench/terminal_port_registers_unit_tb.sv
`timescale 1ns / 1ps

module terminal_port_registers_unit_tb;
    import tpr_pkg::*;

    localparam time CLK_HALF     = 4ns;
    localparam time RUN_LIMIT    = 5ms;    // far beyond the slowest legal run
    localparam int  SLOT_BITS    = 24;
    localparam int  CPU_COUNT    = 16;

    // one bus access, tick or host byte
    typedef struct {
        item_kind_t  kind;
        port_sel_t   port;
        logic [31:0] wdata;
        logic [7:0]  rx;
        logic [3:0]  cpu;
    } port_item_t;

    // what the port answers for one item
    typedef struct {
        logic [31:0] rdata;
        logic        rx_taken;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
        logic [3:0]  irq_cpu;
    } port_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [INTERVAL_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser   = '0;    // [1:0] item kind
    // [1:0] port, [33:2] write_data, [41:34] rx_byte, [45:42] target_cpu, rest 0
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [31:0] read_data, [32] rx_taken, [33] tx_valid, [41:34] tx_byte,
    // [42] irq_request, [46:43] irq_cpu, [47] 0
    logic [M_TDATA_W-1:0]  m_tdata;

    terminal_port_registers_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // stimulus plumbing
    port_item_t   pending_items[$];
    port_result_t expected_results[$];
    int           send_idle_pct  = 0;   // percent of cycles the sender holds off
    int           recv_stall_pct = 0;   // percent of cycles the receiver stalls
    bit           failed         = 1'b0;

    // predicted port state
    logic [23:0] slot_interval;
    logic        rx_avail;
    logic [7:0]  rx_latch;
    logic        tx_busy;
    logic [7:0]  tx_latch;
    logic        rirq;
    logic        wirq;
    logic        wirq_en;
    logic        bad_cmd;
    logic [3:0]  irq_target;
    logic [SLOT_BITS-1:0] slot_count;

    function automatic logic [31:0] status_word();
        logic [31:0] s;
        s = '0;
        s[ST_RAVAIL] = rx_avail;
        s[ST_WBUSY]  = tx_busy;
        s[ST_RIRQ]   = rirq;
        s[ST_WIRQ]   = wirq;
        s[ST_WIRQE]  = wirq_en;
        s[ST_BADCMD] = bad_cmd;
        return s;
    endfunction

    // target CPU only latches when a fresh interrupt starts
    function automatic void raise_target(logic [3:0] cpu);
        if (!rirq && !wirq)
            irq_target = 4'(cpu % CPU_COUNT);
    endfunction

    // advance the predicted port by one item, return its answer
    function automatic port_result_t port_step(port_item_t it);
        port_result_t r;
        logic [23:0]  ivl;
        r = '{default: '0};
        case (it.kind)
            KIND_READ: begin
                if (it.port == PORT_STATUS) begin
                    r.rdata = status_word();
                end else if (it.port == PORT_DATA && rx_avail) begin
                    r.rdata  = {24'd0, rx_latch};
                    rx_avail = 1'b0;
                end
            end
            KIND_WRITE: begin
                if (it.port == PORT_COMMAND) begin
                    // anything but a known code flags an error until the next command
                    bad_cmd = 1'b0;
                    case (it.wdata)
                        CMD_CLR_RIRQ: rirq    = 1'b0;
                        CMD_CLR_WIRQ: wirq    = 1'b0;
                        CMD_EN_WIRQ:  wirq_en = 1'b1;
                        CMD_DIS_WIRQ: wirq_en = 1'b0;
                        default:      bad_cmd = 1'b1;
                    endcase
                end else if (it.port == PORT_DATA && !tx_busy) begin
                    tx_latch = it.wdata[7:0];
                    tx_busy  = 1'b1;
                end
            end
            KIND_TICK: begin
                ivl = (slot_interval == 0) ? 24'd1 : slot_interval;
                if ((slot_count % ivl) == 0 && tx_busy) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = tx_latch;
                    tx_busy    = 1'b0;
                    raise_target(it.cpu);
                    wirq       = 1'b1;
                end
                slot_count = slot_count + 1'b1;   // wraps at the counter width
            end
            default: begin
                if (!rx_avail) begin
                    rx_latch   = it.rx;
                    rx_avail   = 1'b1;
                    r.rx_taken = 1'b1;
                    raise_target(it.cpu);
                    rirq       = 1'b1;
                end
            end
        endcase
        r.irq     = rirq || (wirq && wirq_en);
        r.irq_cpu = irq_target;
        return r;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            failed = 1'b1;
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Driver: a new item goes out only once the current one is taken (or none
    // is up), so tvalid never drops while an item waits for tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                port_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.kind;
                s_tdata  <= {2'b00, it.cpu, it.rx, it.wdata, it.port};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: tracks the config write and accepted items, predicts, and checks
    // each result against the oldest prediction.
    always @(posedge aclk) begin
        port_item_t   it;
        port_result_t want;
        if (!aresetn) begin
            slot_interval = 24'd1;
            rx_avail      = 1'b0;
            rx_latch      = '0;
            tx_busy       = 1'b0;
            tx_latch      = '0;
            rirq          = 1'b0;
            wirq          = 1'b0;
            wirq_en       = 1'b1;
            bad_cmd       = 1'b0;
            irq_target    = '0;
            slot_count    = '0;
        end else begin
            if (cfg_wen)
                slot_interval = cfg_wdata;
            if (s_tvalid && s_tready) begin
                it.kind  = item_kind_t'(s_tuser);
                it.port  = port_sel_t'(s_tdata[1:0]);
                it.wdata = s_tdata[33:2];
                it.rx    = s_tdata[41:34];
                it.cpu   = s_tdata[45:42];
                expected_results.push_back(port_step(it));
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t unexpected result: expected none actual 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    report_field("read_data",   want.rdata,          m_tdata[31:0]);
                    report_field("rx_taken",    32'(want.rx_taken),  32'(m_tdata[32]));
                    report_field("tx_valid",    32'(want.tx_valid),  32'(m_tdata[33]));
                    report_field("tx_byte",     32'(want.tx_byte),   32'(m_tdata[41:34]));
                    report_field("irq_request", 32'(want.irq),       32'(m_tdata[42]));
                    report_field("irq_cpu",     32'(want.irq_cpu),   32'(m_tdata[46:43]));
                    report_field("pad",         32'd0,               32'(m_tdata[47]));
                end
            end
        end
    end

    function automatic port_item_t make_item(item_kind_t kind, port_sel_t port,
                                             logic [31:0] wdata, logic [7:0] rx,
                                             logic [3:0] cpu);
        port_item_t it;
        it.kind  = kind;
        it.port  = port;
        it.wdata = wdata;
        it.rx    = rx;
        it.cpu   = cpu;
        return it;
    endfunction

    // Random item: mostly meaningful traffic (known commands, drains, ticks),
    // with stray codes and full-width noise in every field.
    function automatic port_item_t random_item();
        port_item_t it;
        int         pick;
        pick     = $urandom_range(99);
        it.kind  = (pick < 30) ? KIND_READ : (pick < 60) ? KIND_WRITE :
                   (pick < 80) ? KIND_TICK : KIND_BYTE;
        it.port  = port_sel_t'($urandom_range(3));
        it.wdata = $urandom;
        it.rx    = 8'($urandom);
        it.cpu   = 4'($urandom);
        if (it.kind == KIND_WRITE && it.port == PORT_COMMAND) begin
            pick = $urandom_range(99);
            if (pick < 80)
                it.wdata = $urandom_range(4, 1);
            else if (pick < 90)
                it.wdata = $urandom_range(10, 0);
        end
        return it;
    endfunction

    // blocks until everything sent has been answered
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // register write while the port is idle; tready drops for the realign pass
    task automatic write_interval(logic [23:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_phase(logic [23:0] interval, int idle, int stall, int count);
        write_interval(interval);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) pending_items.push_back(random_item());
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Widest interval while the slot counter still sits at
        // zero, so the very first tick lands on a slot.
        write_interval(24'hFFFFFF);
        pending_items.push_back(make_item(KIND_READ,  PORT_STATUS,   '0, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_DATA,     32'hFFFF_FFFF, '0, '0));
        // holder already full: byte dropped
        pending_items.push_back(make_item(KIND_WRITE, PORT_DATA,     32'h0, '0, '0));
        // slot tick sends, raises the write interrupt, latches CPU 15
        pending_items.push_back(make_item(KIND_TICK,  PORT_STATUS,   '0, '0, 4'hF));
        // read interrupt while one is pending: CPU stays 15
        pending_items.push_back(make_item(KIND_BYTE,  PORT_STATUS,   '0, 8'hFF, 4'h3));
        // receive holder full: not taken
        pending_items.push_back(make_item(KIND_BYTE,  PORT_STATUS,   '0, 8'h00, 4'h0));
        pending_items.push_back(make_item(KIND_READ,  PORT_STATUS,   '0, '0, '0));
        pending_items.push_back(make_item(KIND_READ,  PORT_COMMAND,  '0, '0, '0));
        pending_items.push_back(make_item(KIND_READ,  PORT_DATA,     '0, '0, '0));
        // empty holder reads zero
        pending_items.push_back(make_item(KIND_READ,  PORT_DATA,     '0, '0, '0));
        pending_items.push_back(make_item(KIND_READ,  PORT_UNMAPPED, '0, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_UNMAPPED, 32'hFFFF_FFFF, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_STATUS,   32'hFFFF_FFFF, '0, '0));
        // unknown command codes, then recovery through known ones
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  32'h0, '0, '0));
        pending_items.push_back(make_item(KIND_READ,  PORT_STATUS,   '0, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  32'hFFFF_FFFF, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  32'd5, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  CMD_CLR_RIRQ, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  CMD_DIS_WIRQ, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  CMD_CLR_WIRQ, '0, '0));
        pending_items.push_back(make_item(KIND_WRITE, PORT_COMMAND,  CMD_EN_WIRQ, '0, '0));
        // nothing pending: CPU 0 latches on the new read interrupt
        pending_items.push_back(make_item(KIND_BYTE,  PORT_STATUS,   '0, 8'h00, 4'h0));
        pending_items.push_back(make_item(KIND_READ,  PORT_DATA,     '0, '0, '0));
        // off-slot tick: byte stays held
        pending_items.push_back(make_item(KIND_WRITE, PORT_DATA,     32'h0000_005A, '0, '0));
        pending_items.push_back(make_item(KIND_TICK,  PORT_STATUS,   '0, '0, 4'h7));
        pending_items.push_back(make_item(KIND_READ,  PORT_STATUS,   '0, '0, '0));
        wait_drained();

        // random phases; a zero interval must behave like one
        random_phase(24'd1, 0,  0,  200);
        random_phase(24'd3, 84, 0,  150);
        random_phase(24'd0, 0,  84, 150);
        random_phase(24'($urandom_range(6, 2)), 32, 32, 150);

        repeat (10) @(posedge aclk);
        if (!failed)
            $display("PASS terminal_port_registers_unit");
        else
            $display("FAIL terminal_port_registers_unit");
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT;
        $display("FAIL terminal_port_registers_unit");
        $finish;
    end

endmodule
